### hw/rtl/hdu8f_pkg.sv
// shared codes and types for the half-duplex 8n1 uart with fifos
// no dependencies

package hdu8f_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_ARM   = 2'd3;

  localparam logic [1:0] MODE_READY = 2'd0;
  localparam logic [1:0] MODE_TX    = 2'd1;
  localparam logic [1:0] MODE_ARMED = 2'd2;
  localparam logic [1:0] MODE_RX    = 2'd3;

  localparam logic [3:0] BIT_IDLE = 4'd15;
  localparam logic [3:0] BIT_STOP = 4'd8;

  localparam logic [1:0] CFG_BIT_TICKS   = 2'd0;
  localparam logic [1:0] CFG_START_DELAY = 2'd1;

  localparam logic [7:0] BIT_TICKS_RST   = 8'd104;
  localparam logic [7:0] START_DELAY_RST = 8'd156;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

### hw/rtl/hdu8f_fifo.sv
// byte fifo with a registered front read and write bypass
// depends on hdu8f_pkg

module hdu8f_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hdu8f_pkg::fifo_ctrl_t       ctrl_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  front_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o,
  output logic                        full_o,
  output logic                        empty_o
);
  import hdu8f_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = ctrl_i.push && !full_o;
  assign do_pop  = ctrl_i.pop && !empty_o;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      head_d = (head_q == LAST) ? '0 : head_q + AW'(1);
    end
    if (do_pop) begin
      tail_d = (tail_q == LAST) ? '0 : tail_q + AW'(1);
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[head_q] <= wdata_i;
    end
  end

  // read port tracks the next tail so rd_q always holds the oldest item
  always_ff @(posedge clk_i) begin
    if (do_push && head_q == tail_d) begin
      rd_q <= wdata_i;
    end else begin
      rd_q <= mem_q[tail_d];
    end
  end

  assign front_o = rd_q;
  assign count_o = count_q;

endmodule

### hw/rtl/half_duplex_uart_8n1_fifo.sv
// top level of the half-duplex 8n1 uart with transmit and receive fifos
// depends on hdu8f_pkg and hdu8f_fifo
//
// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o    req_type_i, rx_level_i, tx_byte_i
// out       out  out_valid_o/out_ready_i  tx_level_o, rx_data_o, rx_data_valid_o,
//                                         tx_accepted_o, rx_available_o, busy_res_o, mode_o
// cfg       in   cfg_valid_i/cfg_ready_o  cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while out_ready_i takes the results; a result passes through the
// input register, then the result register, before it is on the outputs
// the fifo front read is registered and follows the next tail pointer
// reset empties both fifos, sets mode ready, line high, config to 104 and 156
// a stalled result holds in the output register; the input register still
// takes one more item, then in_ready_o drops until the result moves

module half_duplex_uart_8n1_fifo #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic       rx_level_i,
  input  logic [7:0] tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_level_o,
  output logic [7:0] rx_data_o,
  output logic       rx_data_valid_o,
  output logic       tx_accepted_o,
  output logic [4:0] rx_available_o,
  output logic       busy_res_o,
  output logic [1:0] mode_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import hdu8f_pkg::*;

  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  // configuration
  logic [7:0] bit_ticks_q, start_delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q   <= BIT_TICKS_RST;
      start_delay_q <= START_DELAY_RST;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == CFG_BIT_TICKS) begin
        bit_ticks_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_START_DELAY) begin
        start_delay_q <= cfg_data_i;
      end
    end
  end

  // input register
  logic       s1_valid_q;
  logic [1:0] req_q;
  logic       lvl_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       s1_fire;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= req_type_i;
      lvl_q  <= rx_level_i;
      byte_q <= tx_byte_i;
    end
  end

  // fifos
  fifo_ctrl_t       tx_ctrl, rx_ctrl, tx_ctrl_g, rx_ctrl_g;
  logic [7:0]       tx_front, rx_front;
  logic [TX_CW-1:0] tx_count;
  logic [RX_CW-1:0] rx_count, rx_count_d;
  logic             tx_full, tx_empty, rx_full, rx_empty;
  logic [7:0]       rx_shift_q, rx_shift_d;

  assign tx_ctrl_g = '{push: tx_ctrl.push && s1_fire, pop: tx_ctrl.pop && s1_fire};
  assign rx_ctrl_g = '{push: rx_ctrl.push && s1_fire, pop: rx_ctrl.pop && s1_fire};

  hdu8f_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl_g),
    .wdata_i (byte_q),
    .front_o (tx_front),
    .count_o (tx_count),
    .full_o  (tx_full),
    .empty_o (tx_empty)
  );

  hdu8f_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl_g),
    .wdata_i (rx_shift_q),
    .front_o (rx_front),
    .count_o (rx_count),
    .full_o  (rx_full),
    .empty_o (rx_empty)
  );

  // line state
  logic [1:0] mode_q, mode_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] tick_q, tick_d;
  logic       line_q, line_d;
  logic       prev_q, prev_d;
  logic [7:0] tick_inc, interval;
  logic       due;
  logic [7:0] rdata;
  logic       rvalid, acc;

  assign tick_inc = tick_q + 8'd1;
  assign interval = (mode_q == MODE_RX && bit_q == '0) ? start_delay_q : bit_ticks_q;
  assign due      = (tick_inc >= interval);

  always_comb begin
    mode_d     = mode_q;
    bit_d      = bit_q;
    rx_shift_d = rx_shift_q;
    tick_d     = tick_q;
    line_d     = line_q;
    prev_d     = prev_q;
    tx_ctrl    = '{push: 1'b0, pop: 1'b0};
    rx_ctrl    = '{push: 1'b0, pop: 1'b0};
    rdata      = '0;
    rvalid     = 1'b0;
    acc        = 1'b0;
    case (req_q)
      REQ_TICK: begin
        prev_d = lvl_q;
        if (mode_q == MODE_TX) begin
          tick_d = due ? '0 : tick_inc;
          if (due) begin
            if (tx_empty) begin
              mode_d = MODE_READY;
              bit_d  = BIT_IDLE;
            end else if (bit_q > BIT_STOP) begin
              line_d = 1'b0;
              bit_d  = '0;
            end else if (bit_q == BIT_STOP) begin
              line_d       = 1'b1;
              bit_d        = BIT_IDLE;
              tx_ctrl.pop  = 1'b1;
            end else begin
              line_d = tx_front[bit_q[2:0]];
              bit_d  = bit_q + 4'd1;
            end
          end
        end else if (mode_q == MODE_RX) begin
          tick_d = due ? '0 : tick_inc;
          if (due) begin
            if (bit_q < BIT_STOP) begin
              rx_shift_d = rx_shift_q | (8'(lvl_q) << bit_q[2:0]);
              bit_d      = bit_q + 4'd1;
            end else begin
              rx_ctrl.push = 1'b1;
              bit_d        = BIT_IDLE;
              mode_d       = MODE_ARMED;
            end
          end
        end else if (mode_q == MODE_ARMED && prev_q && !lvl_q) begin
          mode_d     = MODE_RX;
          bit_d      = '0;
          rx_shift_d = '0;
          tick_d     = '0;
        end
      end
      REQ_WRITE: begin
        if (!tx_full) begin
          tx_ctrl.push = 1'b1;
          acc          = 1'b1;
          if (mode_q != MODE_TX) begin
            mode_d = MODE_TX;
            tick_d = '0;
            bit_d  = BIT_IDLE;
          end
        end
      end
      REQ_READ: begin
        if (!rx_empty) begin
          rdata       = rx_front;
          rvalid      = 1'b1;
          rx_ctrl.pop = 1'b1;
        end
      end
      REQ_ARM: begin
        if (mode_q == MODE_READY) begin
          mode_d = MODE_ARMED;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  assign rx_count_d = rx_count + RX_CW'(rx_ctrl.push && !rx_full) - RX_CW'(rx_ctrl.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_READY;
      bit_q      <= BIT_IDLE;
      rx_shift_q <= '0;
      tick_q     <= '0;
      line_q     <= 1'b1;
      prev_q     <= 1'b1;
    end else if (s1_fire) begin
      mode_q     <= mode_d;
      bit_q      <= bit_d;
      rx_shift_q <= rx_shift_d;
      tick_q     <= tick_d;
      line_q     <= line_d;
      prev_q     <= prev_d;
    end
  end

  // result register
  logic       tx_level_q, rx_data_valid_q, tx_accepted_q, busy_q;
  logic [7:0] rx_data_q;
  logic [4:0] rx_avail_q;
  logic [1:0] mode_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      tx_level_q      <= line_d;
      rx_data_q       <= rdata;
      rx_data_valid_q <= rvalid;
      tx_accepted_q   <= acc;
      rx_avail_q      <= 5'(rx_count_d);
      busy_q          <= (mode_d == MODE_TX);
      mode_out_q      <= mode_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_level_o      = tx_level_q;
  assign rx_data_o       = rx_data_q;
  assign rx_data_valid_o = rx_data_valid_q;
  assign tx_accepted_o   = tx_accepted_q;
  assign rx_available_o  = rx_avail_q;
  assign busy_res_o      = busy_q;
  assign mode_o          = mode_out_q;

  a_line_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_READY || mode_q == MODE_ARMED) |-> line_q)
    else $error("tx line low outside transmit");

  a_rx_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RX) |-> (bit_q <= BIT_STOP))
    else $error("receive bit index out of range");

  a_tx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_count <= TX_CW'(TX_DEPTH))
    else $error("tx fifo overfilled");

  a_rx_read_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && req_q == REQ_READ && !rx_empty) |=>
      (rx_count == $past(rx_count) - RX_CW'(1)))
    else $error("rx read did not pop one item");

endmodule

### dv/testbench.sv
// self-checking testbench for the half-duplex 8n1 uart with transmit and receive fifos
// holds a scoreboard class with its own item-level model of the uart, drives directed and random items
// depends on hdu8f_pkg and half_duplex_uart_8n1_fifo

import hdu8f_pkg::*;

localparam int TX_SLOTS = 16;
localparam int RX_SLOTS = 16;

typedef struct packed {
  logic [1:0] kind;
  logic       level;
  logic [7:0] data;
} uart_req_t;

typedef struct packed {
  logic       tx_line;
  logic [7:0] rd_byte;
  logic       rd_hit;
  logic       wr_taken;
  logic [4:0] rx_fill;
  logic       tx_busy;
  logic [1:0] mode;
} uart_rsp_t;

class uart_scoreboard;
  logic [7:0] bit_period;
  logic [7:0] first_sample;
  logic [1:0] state;
  logic [3:0] bit_pos;
  logic [7:0] shift_in;
  logic [7:0] ticks;
  logic       line;
  logic       last_rx;
  logic [7:0] tx_fifo[$];
  logic [7:0] rx_fifo[$];
  uart_rsp_t  expected_q[$];
  int         n_checked;
  int         n_errors;

  function new();
    bit_period   = BIT_TICKS_RST;
    first_sample = START_DELAY_RST;
    state        = MODE_READY;
    bit_pos      = BIT_IDLE;
    shift_in     = 8'h00;
    ticks        = 8'h00;
    line         = 1'b1;
    last_rx      = 1'b1;
    n_checked    = 0;
    n_errors     = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] value);
    case (idx)
      CFG_BIT_TICKS:   bit_period = value;
      CFG_START_DELAY: first_sample = value;
      default: ;
    endcase
  endfunction

  function bit period_elapsed(logic [7:0] interval);
    ticks = ticks + 8'd1;
    if (ticks >= interval) begin
      ticks = 8'h00;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void next_tx_symbol();
    if (tx_fifo.size() == 0) begin
      state   = MODE_READY;
      bit_pos = BIT_IDLE;
    end else if (bit_pos > BIT_STOP) begin
      line    = 1'b0;
      bit_pos = 4'd0;
    end else if (bit_pos == BIT_STOP) begin
      line    = 1'b1;
      bit_pos = BIT_IDLE;
      void'(tx_fifo.pop_front());
    end else begin
      line    = tx_fifo[0][bit_pos[2:0]];
      bit_pos = bit_pos + 4'd1;
    end
  endfunction

  function void next_rx_sample(logic level);
    if (bit_pos < BIT_STOP) begin
      shift_in[bit_pos[2:0]] = level;
      bit_pos = bit_pos + 4'd1;
    end else begin
      if (rx_fifo.size() < RX_SLOTS) rx_fifo.push_back(shift_in);
      bit_pos = BIT_IDLE;
      state   = MODE_ARMED;
    end
  endfunction

  function uart_rsp_t predict(uart_req_t it);
    uart_rsp_t r;
    r = '0;
    case (it.kind)
      REQ_TICK: begin
        if (state == MODE_TX) begin
          if (period_elapsed(bit_period)) next_tx_symbol();
        end else if (state == MODE_RX) begin
          if (period_elapsed(bit_pos == 4'd0 ? first_sample : bit_period))
            next_rx_sample(it.level);
        end else if (state == MODE_ARMED && last_rx && !it.level) begin
          state    = MODE_RX;
          bit_pos  = 4'd0;
          shift_in = 8'h00;
          ticks    = 8'h00;
        end
        last_rx = it.level;
      end
      REQ_WRITE: begin
        if (tx_fifo.size() < TX_SLOTS) begin
          tx_fifo.push_back(it.data);
          r.wr_taken = 1'b1;
          if (state != MODE_TX) begin
            state   = MODE_TX;
            ticks   = 8'h00;
            bit_pos = BIT_IDLE;
          end
        end
      end
      REQ_READ: begin
        if (rx_fifo.size() != 0) begin
          r.rd_byte = rx_fifo.pop_front();
          r.rd_hit  = 1'b1;
        end
      end
      default: begin
        if (state == MODE_READY) state = MODE_ARMED;
      end
    endcase
    r.tx_line = line;
    r.rx_fill = 5'(rx_fifo.size());
    r.tx_busy = (state == MODE_TX);
    r.mode    = state;
    return r;
  endfunction

  function void note_item(uart_req_t it);
    expected_q.push_back(predict(it));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             n_checked, what, got_v, want_v);
    n_errors++;
  endtask

  task check_result(uart_rsp_t got);
    uart_rsp_t want;
    n_checked++;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing expected", got, 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.tx_line !== want.tx_line) report_mismatch("tx_level", got.tx_line, want.tx_line);
    if (got.rd_byte !== want.rd_byte) report_mismatch("rx_data", got.rd_byte, want.rd_byte);
    if (got.rd_hit !== want.rd_hit)
      report_mismatch("rx_data_valid", got.rd_hit, want.rd_hit);
    if (got.wr_taken !== want.wr_taken)
      report_mismatch("tx_accepted", got.wr_taken, want.wr_taken);
    if (got.rx_fill !== want.rx_fill)
      report_mismatch("rx_available", got.rx_fill, want.rx_fill);
    if (got.tx_busy !== want.tx_busy) report_mismatch("busy_res", got.tx_busy, want.tx_busy);
    if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
  endtask
endclass

module testbench;

  typedef enum int {EP_RECV, EP_XMIT, EP_DRAIN, EP_NOISE} episode_e;

  localparam int LONG_HOLD = 80;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i = REQ_TICK;
  logic       rx_level_i = 1'b1;
  logic [7:0] tx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       tx_level_o;
  logic [7:0] rx_data_o;
  logic       rx_data_valid_o;
  logic       tx_accepted_o;
  logic [4:0] rx_available_o;
  logic       busy_res_o;
  logic [1:0] mode_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_idx_i = CFG_BIT_TICKS;
  logic [7:0] cfg_data_i = 8'h00;

  uart_scoreboard sb;
  bit send_fast;
  bit rcv_fast;
  bit hold_off_req;
  bit rx_wave[$];
  int line_bit_ticks = BIT_TICKS_RST;

  half_duplex_uart_8n1_fifo #(
    .TX_DEPTH(TX_SLOTS),
    .RX_DEPTH(RX_SLOTS)
  ) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic int gap_draw(bit fast);
    return fast ? 0 : int'($urandom_range(0, 13));
  endfunction

  // receive line follows whole 8n1 frames, with a rare glitch
  function automatic bit next_rx_level();
    bit lvl;
    logic [7:0] b;
    if (rx_wave.size() == 0) begin
      b = 8'($urandom);
      repeat ($urandom_range(0, 2 * line_bit_ticks)) rx_wave.push_back(1'b1);
      repeat (line_bit_ticks) rx_wave.push_back(1'b0);
      for (int i = 0; i < 8; i++) repeat (line_bit_ticks) rx_wave.push_back(b[i]);
      repeat (line_bit_ticks) rx_wave.push_back(1'b1);
    end
    lvl = rx_wave.pop_front();
    if ($urandom_range(0, 49) == 0) lvl = !lvl;
    return lvl;
  endfunction

  function automatic uart_req_t next_item(episode_e ep, int read_pct);
    uart_req_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it = '{kind: REQ_TICK, level: 1'b1, data: 8'($urandom)};
    case (ep)
      EP_RECV: begin
        if (roll < read_pct) it.kind = REQ_READ;
        else if (roll < read_pct + 4) it.kind = REQ_ARM;
        else if (roll == 99) it.kind = REQ_WRITE;
        else it.level = next_rx_level();
      end
      EP_XMIT: begin
        if (roll < 30) it.kind = REQ_WRITE;
        else if (roll < 38) it.kind = REQ_READ;
        else it.level = 1'($urandom);
      end
      EP_DRAIN: begin
        if (roll < 50) it.kind = REQ_READ;
        else it.level = next_rx_level();
      end
      default: begin
        it.kind  = 2'($urandom);
        it.level = 1'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic send_item(uart_req_t it);
    int gap;
    gap = gap_draw(send_fast);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= it.kind;
    rx_level_i <= it.level;
    tx_byte_i  <= it.data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_regs(logic [7:0] period, logic [7:0] delay);
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= CFG_BIT_TICKS;
    cfg_data_i  <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_BIT_TICKS, period);
    cfg_idx_i  <= CFG_START_DELAY;
    cfg_data_i <= delay;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_START_DELAY, delay);
    cfg_valid_i <= 1'b0;
    line_bit_ticks = period;
    rx_wave.delete();
  endtask

  task automatic run_random(int n_items);
    int sent;
    int ep_no;
    int ep_len;
    int read_pct;
    int roll;
    episode_e ep;
    sent  = 0;
    ep_no = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      ep = roll < 40 ? EP_RECV : roll < 65 ? EP_XMIT : roll < 75 ? EP_DRAIN : EP_NOISE;
      ep_len   = $urandom_range(20, 80);
      read_pct = $urandom_range(0, 1) ? 0 : 15;
      send_fast = ($urandom_range(0, 2) == 0);
      // long receiver stall while items keep coming
      if (ep_no == 2) begin
        send_fast = 1'b1;
        hold_off_req = 1'b1;
      end
      if (ep_no == 4) wait_results_drained();
      if (ep == EP_RECV) begin
        send_item('{kind: REQ_ARM, level: 1'b1, data: 8'($urandom)});
        sent++;
      end
      if (ep == EP_XMIT && $urandom_range(0, 2) == 0) begin
        repeat (TX_SLOTS + 1) begin
          send_item('{kind: REQ_WRITE, level: 1'($urandom), data: 8'($urandom)});
          sent++;
        end
      end
      repeat (ep_len) begin
        send_item(next_item(ep, read_pct));
        sent++;
      end
      ep_no++;
    end
  endtask

  initial begin
    int hold;
    uart_rsp_t got;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{tx_line: tx_level_o, rd_byte: rx_data_o, rd_hit: rx_data_valid_o,
                wr_taken: tx_accepted_o, rx_fill: rx_available_o, tx_busy: busy_res_o,
                mode: mode_o};
        sb.check_result(got);
        if ($urandom_range(0, 49) == 0) rcv_fast = !rcv_fast;
        hold = gap_draw(rcv_fast);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    uart_req_t seq[$];
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty read, arming, edge, arm ignored, write aborts reception, tx fifo overflow
    seq.push_back('{kind: REQ_READ, level: 1'b1, data: 8'h00});
    seq.push_back('{kind: REQ_TICK, level: 1'b0, data: 8'h00});
    seq.push_back('{kind: REQ_ARM, level: 1'b1, data: 8'h00});
    seq.push_back('{kind: REQ_ARM, level: 1'b0, data: 8'hFF});
    seq.push_back('{kind: REQ_TICK, level: 1'b1, data: 8'h00});
    seq.push_back('{kind: REQ_TICK, level: 1'b0, data: 8'h00});
    seq.push_back('{kind: REQ_ARM, level: 1'b1, data: 8'h00});
    seq.push_back('{kind: REQ_WRITE, level: 1'b1, data: 8'hFF});
    seq.push_back('{kind: REQ_ARM, level: 1'b1, data: 8'h00});
    seq.push_back('{kind: REQ_TICK, level: 1'b0, data: 8'h00});
    seq.push_back('{kind: REQ_WRITE, level: 1'b0, data: 8'h00});
    repeat (TX_SLOTS - 2) seq.push_back('{kind: REQ_WRITE, level: 1'b1, data: 8'($urandom)});
    seq.push_back('{kind: REQ_WRITE, level: 1'b1, data: 8'hA5});
    foreach (seq[i]) send_item(seq[i]);

    run_random(80);
    write_regs(8'd1, 8'd1);
    run_random(500);
    write_regs(8'd255, 8'd255);
    run_random(80);
    write_regs(8'd2, 8'd3);
    run_random(450);
    write_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)));
    run_random(450);
    write_regs(8'd1, 8'd255);
    run_random(200);
    in_valid_i <= 1'b0;

    for (int k = 0; k < 20000 && sb.pending() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("results never arrived", sb.pending(), 0);
    if (sb.n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### half_duplex_uart_8n1_fifo.f
hw/rtl/hdu8f_pkg.sv
hw/rtl/hdu8f_fifo.sv
hw/rtl/half_duplex_uart_8n1_fifo.sv
dv/testbench.sv
